// ===== rtl/filru_pkg.sv =====
`default_nettype none

package filru_pkg;

  // Kind bits that make an open not cacheable: directory and append-only.
  localparam logic [7:0] KIND_NOCACHE_MASK = 8'hC0;

  // Width of the slot field in a result.
  localparam int SLOT_OUT_W = 6;

  // Entries in the request queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OUT_NOCACHE  = 2'd0,
    OUT_HIT_SAME = 2'd1,
    OUT_HIT_NEW  = 2'd2,
    OUT_MISS     = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CMP,
    BK_UPD
  } back_state_e;

  // One classified request as it travels through the queue.
  typedef struct packed {
    logic [63:0] path;
    logic [7:0]  kind;
    logic [31:0] version;
    logic [31:0] devnum;
    logic [15:0] devtype;
    logic        nocache;
  } item_t;

  // Update command from the back engine to the entry cells.
  typedef struct packed {
    logic touch;      // move the selected entry to most recent
    logic write_tag;  // install the identity into the selected entry
    logic write_ver;  // store the request version into the selected entry
  } upd_t;

endpackage

`default_nettype wire

// ===== rtl/filru_front.sv =====
`default_nettype none

// Accepts requests, classifies them and holds them in a short queue.
module filru_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic [63:0]         file_path_i,
  input  wire logic [7:0]          file_kind_i,
  input  wire logic [31:0]         file_version_i,
  input  wire logic [31:0]         device_number_i,
  input  wire logic [15:0]         device_type_i,
  output logic                     full_o,
  output logic                     head_valid_o,
  output filru_pkg::item_t         head_o,
  input  wire logic                pop_i
);

  localparam int PtrW = $clog2(filru_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(filru_pkg::QUEUE_DEPTH + 1);

  filru_pkg::item_t          slots_q [filru_pkg::QUEUE_DEPTH];
  filru_pkg::item_t          new_item;
  logic [PtrW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]           count_q, count_d;
  logic                      do_push, do_pop;

  always_comb begin
    new_item.path    = file_path_i;
    new_item.kind    = file_kind_i;
    new_item.version = file_version_i;
    new_item.devnum  = device_number_i;
    new_item.devtype = device_type_i;
    new_item.nocache = |(file_kind_i & filru_pkg::KIND_NOCACHE_MASK);
  end

  assign full_o       = (count_q == CntW'(filru_pkg::QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(filru_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(filru_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/filru_cells.sv =====
`default_nettype none

// Row of entry cells: each holds one identity, its version, a valid bit and
// its recency rank, and compares itself against the current request.
module filru_cells #(
  parameter int ENTRIES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire filru_pkg::item_t    key_i,
  input  wire filru_pkg::upd_t     upd_i,
  input  wire logic [ENTRIES-1:0]  sel_i,
  output logic [ENTRIES-1:0]       match_o,
  output logic [ENTRIES-1:0]       ver_ne_o,
  output logic [ENTRIES-1:0]       lru_o
);

  localparam int SlotW = $clog2(ENTRIES);

  logic [SlotW-1:0] rank_q [ENTRIES];
  logic [SlotW-1:0] sel_rank;

  // Rank of the selected entry; sel_i is one-hot when an update runs.
  always_comb begin
    sel_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel_i[i]) begin
        sel_rank = sel_rank | rank_q[i];
      end
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [63:0] path_q;
    logic [7:0]  kind_q;
    logic [31:0] devnum_q;
    logic [15:0] devtype_q;
    logic [31:0] version_q;
    logic        valid_q;

    assign match_o[g]  = valid_q && (path_q == key_i.path) && (kind_q == key_i.kind) &&
                         (devnum_q == key_i.devnum) && (devtype_q == key_i.devtype);
    assign ver_ne_o[g] = (version_q != key_i.version);
    assign lru_o[g]    = (rank_q[g] == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q   <= 1'b0;
        rank_q[g] <= SlotW'(g);
      end else begin
        if (upd_i.write_tag && sel_i[g]) begin
          valid_q <= 1'b1;
        end
        if (upd_i.touch) begin
          if (sel_i[g]) begin
            rank_q[g] <= SlotW'(ENTRIES - 1);
          end else if (rank_q[g] > sel_rank) begin
            rank_q[g] <= rank_q[g] - 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (upd_i.write_tag && sel_i[g]) begin
        path_q    <= key_i.path;
        kind_q    <= key_i.kind;
        devnum_q  <= key_i.devnum;
        devtype_q <= key_i.devtype;
      end
      if (upd_i.write_ver && sel_i[g]) begin
        version_q <= key_i.version;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/filru_back.sv =====
`default_nettype none

// Back engine: takes a request from the queue, runs a compare cycle and an
// update cycle against the entry cells, and registers the result.
module filru_back #(
  parameter int ENTRIES = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              head_valid_i,
  input  wire filru_pkg::item_t                  head_i,
  output logic                                   pop_o,
  output filru_pkg::item_t                       key_o,
  output filru_pkg::upd_t                        upd_o,
  output logic [ENTRIES-1:0]                     sel_o,
  input  wire logic [ENTRIES-1:0]                match_i,
  input  wire logic [ENTRIES-1:0]                ver_ne_i,
  input  wire logic [ENTRIES-1:0]                lru_i,
  output logic                                   done_o,
  output logic [1:0]                             outcome_o,
  output logic [filru_pkg::SLOT_OUT_W-1:0]       slot_index_o
);

  localparam int SlotW = $clog2(ENTRIES);

  function automatic logic [SlotW-1:0] encode(input logic [ENTRIES-1:0] vec);
    logic [SlotW-1:0] idx;
    idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (vec[i]) begin
        idx = idx | SlotW'(i);
      end
    end
    return idx;
  endfunction

  filru_pkg::back_state_e state_q, state_d;
  filru_pkg::item_t       work_q;
  logic [ENTRIES-1:0]     match_q, lru_q;
  logic                   ver_ne_q;
  logic                   cmp_en, upd_en, hit;
  logic [SlotW-1:0]       slot;
  logic [SlotW+filru_pkg::SLOT_OUT_W-1:0] slot_ext;
  filru_pkg::outcome_e    outcome;
  logic                   done_q;
  filru_pkg::outcome_e    outcome_q;
  logic [filru_pkg::SLOT_OUT_W-1:0] slot_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      filru_pkg::BK_IDLE: begin
        if (head_valid_i) begin
          state_d = filru_pkg::BK_CMP;
        end
      end
      filru_pkg::BK_CMP: begin
        state_d = filru_pkg::BK_UPD;
      end
      filru_pkg::BK_UPD: begin
        state_d = head_valid_i ? filru_pkg::BK_CMP : filru_pkg::BK_IDLE;
      end
      default: begin
        state_d = filru_pkg::BK_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    pop_o  = 1'b0;
    cmp_en = 1'b0;
    upd_en = 1'b0;
    case (state_q)
      filru_pkg::BK_IDLE: begin
        pop_o = head_valid_i;
      end
      filru_pkg::BK_CMP: begin
        cmp_en = 1'b1;
      end
      filru_pkg::BK_UPD: begin
        upd_en = 1'b1;
        pop_o  = head_valid_i;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  assign key_o    = work_q;
  assign hit      = |match_q;
  assign sel_o    = hit ? match_q : lru_q;
  assign slot     = encode(sel_o);
  assign slot_ext = {{filru_pkg::SLOT_OUT_W{1'b0}}, slot};

  always_comb begin
    upd_o.touch     = upd_en && !work_q.nocache;
    upd_o.write_tag = upd_en && !work_q.nocache && !hit;
    upd_o.write_ver = upd_en && !work_q.nocache && (!hit || ver_ne_q);
    if (work_q.nocache) begin
      outcome = filru_pkg::OUT_NOCACHE;
    end else if (!hit) begin
      outcome = filru_pkg::OUT_MISS;
    end else if (ver_ne_q) begin
      outcome = filru_pkg::OUT_HIT_NEW;
    end else begin
      outcome = filru_pkg::OUT_HIT_SAME;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= filru_pkg::BK_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= upd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q <= head_i;
    end
    if (cmp_en) begin
      match_q  <= match_i;
      lru_q    <= lru_i;
      ver_ne_q <= |(match_i & ver_ne_i);
    end
    if (upd_en) begin
      outcome_q <= outcome;
      slot_q    <= work_q.nocache ? '0 : slot_ext[filru_pkg::SLOT_OUT_W-1:0];
    end
  end

  assign done_o       = done_q;
  assign outcome_o    = outcome_q;
  assign slot_index_o = slot_q;

endmodule

`default_nettype wire

// ===== rtl/file_identity_lru_table_top.sv =====
`default_nettype none

// File identity table with least-recently-used replacement. Each request is
// one file open; it is taken at a rising edge where start is high and busy is
// low, and exactly one result follows, on done_o for a single cycle. The
// receiver cannot stall: a result must be taken in the cycle it is shown.
// Results come back in request order. A back engine handles each request in
// a compare cycle, in which all entries match against the request in
// parallel, and an update cycle that reorders the recency ranks and writes the
// entry; it takes the next queued request during that update cycle. A lone
// request passes through a queue slot, the work register, the compare
// registers and the result register before done_o rises.
// A two-entry queue stands between the front and the back engine; busy rises
// only while that queue is full. Opens of directories or append-only files
// are reported as not cacheable with slot zero and leave the table unchanged.
// After reset the table is empty and misses fill slots 0, 1, 2 and so on.
module file_identity_lru_table_top #(
  parameter int ENTRIES = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [63:0]                         file_path_i,
  input  wire logic [7:0]                          file_kind_i,
  input  wire logic [31:0]                         file_version_i,
  input  wire logic [31:0]                         device_number_i,
  input  wire logic [15:0]                         device_type_i,
  output logic                                     done_o,
  output logic [1:0]                               outcome_o,
  output logic [filru_pkg::SLOT_OUT_W-1:0]         slot_index_o
);

  filru_pkg::item_t   head;
  filru_pkg::item_t   key;
  filru_pkg::upd_t    upd;
  logic               head_valid;
  logic               pop;
  logic [ENTRIES-1:0] sel, match, ver_ne, lru;

  // Front: accepts and classifies requests and queues them.
  filru_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (start),
    .file_path_i     (file_path_i),
    .file_kind_i     (file_kind_i),
    .file_version_i  (file_version_i),
    .device_number_i (device_number_i),
    .device_type_i   (device_type_i),
    .full_o          (busy),
    .head_valid_o    (head_valid),
    .head_o          (head),
    .pop_i           (pop)
  );

  // Back: compare and update sequencing plus the result register.
  filru_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .key_o        (key),
    .upd_o        (upd),
    .sel_o        (sel),
    .match_i      (match),
    .ver_ne_i     (ver_ne),
    .lru_i        (lru),
    .done_o       (done_o),
    .outcome_o    (outcome_o),
    .slot_index_o (slot_index_o)
  );

  // Entry cells: identities, versions, valid bits and recency ranks.
  filru_cells #(
    .ENTRIES (ENTRIES)
  ) u_cells (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (key),
    .upd_i    (upd),
    .sel_i    (sel),
    .match_o  (match),
    .ver_ne_o (ver_ne),
    .lru_o    (lru)
  );

endmodule

`default_nettype wire

// ===== rtl/filru_checker.sv =====
`default_nettype none

module filru_checker #(
  parameter int ENTRIES = 64
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done_o,
  input wire logic [1:0]                    outcome_o,
  input wire logic [filru_pkg::SLOT_OUT_W-1:0] slot_index_o
);

  // A not-cacheable result always names slot zero.
  a_nocache_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && outcome_o == filru_pkg::OUT_NOCACHE) |-> (slot_index_o == '0))
    else $error("not-cacheable result with nonzero slot");

  // Each request passes through the compare state before its update state, so results never come back to back.
  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results in consecutive cycles");

  // The queue only fills through an accepted request.
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted request");

  // A cached slot lies inside the table.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && outcome_o != filru_pkg::OUT_NOCACHE) |->
      ((ENTRIES >= 64) || (32'(slot_index_o) < ENTRIES)))
    else $error("slot outside the table");

endmodule

bind file_identity_lru_table_top filru_checker #(
  .ENTRIES (ENTRIES)
) u_filru_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .outcome_o    (outcome_o),
  .slot_index_o (slot_index_o)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

// Checks the file identity table with least-recently-used replacement.
// Each request is one file open. The testbench keeps its own model of the
// entries and of the recency ranks, predicts the outcome and slot of every
// accepted request, and compares each result on done_o with the oldest
// prediction still pending.
module testbench;

  localparam int ENTRIES      = 64;
  localparam int SLOT_W       = $clog2(ENTRIES);
  localparam int SLOT_OUT_W   = filru_pkg::SLOT_OUT_W;
  localparam int RANDOM_OPENS = 680;
  localparam int POOL_MAX     = 128;
  // Cycles with neither a request nor a result taken before the run is abandoned.
  // The longest correct quiet stretch is a sender gap of up to gap_max plus the
  // time a lone request takes to come back, so this leaves a wide margin.
  localparam int QUIET_LIMIT  = 400;
  // Cycles to keep watching for stray results at the end, longer than a lone request takes.
  localparam int DRAIN_CYCLES = 16;

  // One file open as the sender presents it.
  typedef struct packed {
    logic [63:0] path;
    logic [7:0]  kind;
    logic [31:0] version;
    logic [31:0] devnum;
    logic [15:0] devtype;
  } file_open_t;

  // One predicted result.
  typedef struct packed {
    filru_pkg::outcome_e outcome;
    logic [SLOT_W-1:0]   slot;
  } open_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start           = 1'b0;
  logic [63:0] file_path_i     = '0;
  logic [7:0]  file_kind_i     = '0;
  logic [31:0] file_version_i  = '0;
  logic [31:0] device_number_i = '0;
  logic [15:0] device_type_i   = '0;
  logic        busy;
  logic        done_o;
  logic [1:0]  outcome_o;
  logic [SLOT_OUT_W-1:0] slot_index_o;

  file_identity_lru_table_top #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .file_path_i    (file_path_i),
    .file_kind_i    (file_kind_i),
    .file_version_i (file_version_i),
    .device_number_i(device_number_i),
    .device_type_i  (device_type_i),
    .done_o         (done_o),
    .outcome_o      (outcome_o),
    .slot_index_o   (slot_index_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the table. Rank 0 of lru_rank is the least recent slot and
  // rank ENTRIES-1 the most recent one.
  logic [63:0]       id_path    [ENTRIES];
  logic [7:0]        id_kind    [ENTRIES];
  logic [31:0]       id_devnum  [ENTRIES];
  logic [15:0]       id_devtype [ENTRIES];
  logic [31:0]       id_version [ENTRIES];
  logic              id_valid   [ENTRIES];
  logic [SLOT_W-1:0] lru_rank   [ENTRIES];

  open_result_t pending_results[$];
  open_result_t oldest_result;
  int           mismatches  = 0;
  int           quiet_cycles = 0;
  // Largest gap the sender may draw before a request; zero gives a stretch of
  // back-to-back requests that fills the queue and makes busy assert.
  int           gap_max     = 16;

  // Identities that the random part reopens so that hits and evictions occur.
  file_open_t   open_pool[POOL_MAX];
  int           pool_size   = 24;

  function automatic void clear_table_model();
    for (int i = 0; i < ENTRIES; i++) begin
      id_path[i]    = '0;
      id_kind[i]    = '0;
      id_devnum[i]  = '0;
      id_devtype[i] = '0;
      id_version[i] = '0;
      id_valid[i]   = 1'b0;
      lru_rank[i]   = SLOT_W'(i);
    end
  endfunction

  // Works out the result of one open and applies it to the shadow table.
  function automatic open_result_t predict_open(input file_open_t op);
    open_result_t      res;
    int                hit_rank;
    logic [SLOT_W-1:0] slot;
    res.outcome = filru_pkg::OUT_NOCACHE;
    res.slot    = '0;
    hit_rank    = -1;
    // Directory and append-only opens bypass the table entirely.
    if ((op.kind & filru_pkg::KIND_NOCACHE_MASK) != 8'h00) begin
      return res;
    end
    // The version takes no part in the match.
    for (int rank = 0; rank < ENTRIES; rank++) begin
      slot = lru_rank[rank];
      if (hit_rank < 0 && id_valid[slot] && id_path[slot] == op.path &&
          id_kind[slot] == op.kind && id_devnum[slot] == op.devnum &&
          id_devtype[slot] == op.devtype) begin
        hit_rank = rank;
      end
    end
    if (hit_rank >= 0) begin
      slot = lru_rank[hit_rank];
      if (id_version[slot] != op.version) begin
        res.outcome = filru_pkg::OUT_HIT_NEW;
      end else begin
        res.outcome = filru_pkg::OUT_HIT_SAME;
      end
      id_version[slot] = op.version;
    end else begin
      // A miss takes over the least recent slot.
      hit_rank         = 0;
      slot             = lru_rank[0];
      id_path[slot]    = op.path;
      id_kind[slot]    = op.kind;
      id_devnum[slot]  = op.devnum;
      id_devtype[slot] = op.devtype;
      id_version[slot] = op.version;
      id_valid[slot]   = 1'b1;
      res.outcome      = filru_pkg::OUT_MISS;
    end
    for (int rank = hit_rank; rank < ENTRIES - 1; rank++) begin
      lru_rank[rank] = lru_rank[rank + 1];
    end
    lru_rank[ENTRIES - 1] = slot;
    res.slot = slot;
    return res;
  endfunction

  // Sends one request. The task is entered right after a rising edge and
  // returns right after the edge that accepted the request, with start still
  // high, so a following call without a gap keeps start high throughout.
  task automatic open_file(input file_open_t op);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    file_path_i     <= op.path;
    file_kind_i     <= op.kind;
    file_version_i  <= op.version;
    device_number_i <= op.devnum;
    device_type_i   <= op.devtype;
    // Values read right after the edge are the ones the block sampled there.
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_results.push_back(predict_open(op));
  endtask

  function automatic file_open_t make_open(input logic [63:0] path, input logic [7:0] kind,
                                           input logic [31:0] version,
                                           input logic [31:0] devnum,
                                           input logic [15:0] devtype);
    file_open_t op;
    op.path    = path;
    op.kind    = kind;
    op.version = version;
    op.devnum  = devnum;
    op.devtype = devtype;
    return op;
  endfunction

  function automatic file_open_t random_identity();
    return make_open({$urandom, $urandom}, 8'($urandom_range(0, 63)), $urandom, $urandom,
                     16'($urandom));
  endfunction

  // After reset the table is empty, so even the all-zero identity misses and
  // the first misses land in slots 0, 1 and 2.
  task automatic test_first_fill();
    open_file(make_open('0, 8'h00, '0, '0, '0));
    open_file(make_open('1, 8'h3F, '1, '1, '1));
    open_file(make_open(64'h0123_4567_89AB_CDEF, 8'h15, 32'h0000_0007, 32'h0000_0002,
                        16'h00A5));
  endtask

  // Directory and append-only kinds give outcome not cacheable with slot zero,
  // even when the rest of the identity matches a stored entry.
  task automatic test_not_cacheable();
    open_file(make_open('1, 8'h80, '1, '1, '1));
    open_file(make_open('1, 8'h40, '1, '1, '1));
    open_file(make_open('0, 8'hC0, '0, '0, '0));
    open_file(make_open('1, 8'hFF, '1, '1, '1));
  endtask

  // Reopening a stored identity hits; a changed version is stored and
  // reported, and the stored version then counts as the same.
  task automatic test_hit_versions();
    open_file(make_open('0, 8'h00, '0, '0, '0));
    open_file(make_open('0, 8'h00, 32'hFFFF_FFFF, '0, '0));
    open_file(make_open('0, 8'h00, 32'hFFFF_FFFF, '0, '0));
    open_file(make_open('0, 8'h00, '0, '0, '0));
    open_file(make_open('1, 8'h3F, 32'h8000_0001, '1, '1));
  endtask

  // Identities that differ from a stored one in a single matched field miss.
  task automatic test_partial_match();
    file_open_t base;
    file_open_t near;
    base = make_open(64'hFEDC_BA98_7654_3210, 8'h2A, 32'h1234_5678, 32'h0BAD_F00D, 16'h5A5A);
    open_file(base);
    near = base;
    near.path[63] = ~near.path[63];
    open_file(near);
    near = base;
    near.kind[0] = ~near.kind[0];
    open_file(near);
    near = base;
    near.devnum[31] = ~near.devnum[31];
    open_file(near);
    near = base;
    near.devtype[0] = ~near.devtype[0];
    open_file(near);
    open_file(base);
    near = base;
    near.kind = near.kind | 8'h80;
    open_file(near);
    open_file(base);
  endtask

  // Most random requests reopen identities from a pool, so that hits, version
  // changes and evictions all occur. The pool size alternates between blocks
  // that fit in the table and blocks that overflow it, and some blocks run
  // without any sender gaps. The rest are near misses, non-cacheable opens and
  // fully random identities.
  task automatic test_random_opens();
    file_open_t op;
    int         pick;
    int         roll;
    int         bit_sel;
    for (int i = 0; i < POOL_MAX; i++) begin
      open_pool[i] = random_identity();
    end
    for (int n = 0; n < RANDOM_OPENS; n++) begin
      if (n % 80 == 0) begin
        pool_size = ((n / 80) % 2 == 0) ? $urandom_range(8, 48) : $urandom_range(70, POOL_MAX);
        gap_max   = ((n / 80) % 3 == 2) ? 0 : 16;
      end
      pick = $urandom_range(0, pool_size - 1);
      roll = $urandom_range(0, 99);
      op   = open_pool[pick];
      if (roll < 65) begin
        // Reopen, with the version kept or changed.
        if ($urandom_range(0, 1) == 1) begin
          op.version = $urandom;
          open_pool[pick].version = op.version;
        end
      end else if (roll < 75) begin
        // Near miss: one matched field changes in one bit.
        case ($urandom_range(0, 3))
          0: begin
            bit_sel = $urandom_range(0, 63);
            op.path[bit_sel] = ~op.path[bit_sel];
          end
          1: begin
            bit_sel = $urandom_range(0, 5);
            op.kind[bit_sel] = ~op.kind[bit_sel];
          end
          2: begin
            bit_sel = $urandom_range(0, 31);
            op.devnum[bit_sel] = ~op.devnum[bit_sel];
          end
          default: begin
            bit_sel = $urandom_range(0, 15);
            op.devtype[bit_sel] = ~op.devtype[bit_sel];
          end
        endcase
      end else if (roll < 88) begin
        // Directory or append-only kind on an identity that may be stored.
        op.kind = 8'($urandom_range(64, 255));
      end else if (roll < 95) begin
        op = random_identity();
        open_pool[pick] = op;
      end else begin
        op = random_identity();
      end
      open_file(op);
    end
  endtask

  // Every result is taken in the one cycle it is shown and compared with the
  // oldest pending prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending: outcome %0d slot %0d",
                 $time, outcome_o, slot_index_o);
        mismatches++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (outcome_o !== oldest_result.outcome) begin
          $display("%0t: outcome expected %0d actual %0d",
                   $time, oldest_result.outcome, outcome_o);
          mismatches++;
        end
        if (slot_index_o !== SLOT_OUT_W'(oldest_result.slot)) begin
          $display("%0t: slot_index expected %0d actual %0d",
                   $time, oldest_result.slot, slot_index_o);
          mismatches++;
        end
      end
    end
  end

  // Counts cycles in which neither a request nor a result is taken.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    clear_table_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_fill();
    test_not_cacheable();
    test_hit_versions();
    test_partial_match();
    test_random_opens();
    start <= 1'b0;
    // Let every pending request come back, then watch a little longer for
    // stray results.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
